### rtl/core/esc_pkg.sv
package esc_pkg;

  // Request selector codes
  localparam logic [1:0] REQ_TEMP  = 2'd0;
  localparam logic [1:0] REQ_HUM   = 2'd1;
  localparam logic [1:0] REQ_PRESS = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // Trim register indexes
  localparam logic [2:0] REG_TEMP_TRIM    = 3'd0;
  localparam logic [2:0] REG_PRESS_TRIM_A = 3'd1;
  localparam logic [2:0] REG_PRESS_TRIM_B = 3'd2;
  localparam logic [2:0] REG_PRESS_TRIM_C = 3'd3;
  localparam logic [2:0] REG_HUM_TRIM     = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Numeric constants of the compensation formulas
  localparam logic [31:0] HUM_T_OFS   = 32'd76800;
  localparam logic [31:0] HUM_MAX     = 32'd419430400;
  localparam logic [63:0] PRESS_T_OFS = 64'd128000;
  localparam logic [63:0] PRESS_MAX   = 64'd33554431;
  localparam logic [63:0] PRESS_FS    = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE = 64'd3125;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DIV,
    ST_OUT
  } state_t;

  // Sequencer steps, one per operation of the shared datapath
  typedef enum logic [5:0] {
    S_T0, S_T1, S_T2, S_T3, S_T4,
    S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8, S_H9,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
    S_P10, S_P11, S_P12, S_P13, S_P14, S_P15, S_P16, S_P17, S_P18
  } step_t;

endpackage

### rtl/core/env_sensor_compensation_unit.sv
// Channel  Direction  Handshake          Word
// in_      input      in_valid/in_stall  req_type, raw_value
// out_     output     out_valid/out_stall value, error
// cfg_     input      cfg_valid/cfg_ready index, data (ready always high)
//
// One item at a time through a shared 32x32 multiplier (64-bit wrapping
// product) and a 1-bit-per-cycle restoring divider.
// Reset clears the trim registers, the fine-temperature state and control.
// in_stall is high from acceptance until the result is in the output
// register; a held result does not block the next item from being accepted.
module env_sensor_compensation_unit
  import esc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_req_type,
  input  logic [19:0]           in_raw_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_value,
  output logic                  out_error,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] MUL_LAST = 3'd4;

  function automatic logic [63:0] sra64(input logic [63:0] x, input logic [5:0] n);
    sra64 = 64'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sra32(input logic [31:0] x, input logic [4:0] n);
    sra32 = 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] x);
    sx16 = {{48{x[15]}}, x};
  endfunction

  state_t       state_r, state_nxt;
  step_t        step_r, step_nxt;
  logic [2:0]   phase_r, phase_nxt;
  logic [5:0]   div_cnt_r, div_cnt_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         ft_valid_r, ft_valid_nxt;

  logic [47:0]  temp_trim_r;
  logic [63:0]  press_a_r, press_b_r, hum_trim_r;
  logic [15:0]  press_c_r;
  logic [31:0]  fine_temp_r, fine_temp_nxt;

  logic [19:0]  raw_r, raw_nxt;
  logic [63:0]  ra_r, ra_nxt, rb_r, rb_nxt, rc_r, rc_nxt, rd_r, rd_nxt;
  logic [63:0]  pp_r, pp_nxt, acc_r, acc_nxt, prod_r, prod_nxt;
  logic [63:0]  dq_r, dq_nxt, dvs_r, dvs_nxt, rem_r, rem_nxt;
  logic         dneg_r, dneg_nxt;
  logic [31:0]  res_val_r, res_val_nxt, out_value_r, out_value_nxt;
  logic         res_err_r, res_err_nxt, out_error_r, out_error_nxt;

  logic         mul_en;
  logic [63:0]  mx, my;
  logic [31:0]  mul_a, mul_b;

  // Trim fields
  logic [63:0]  t1, t2, t3, d1, d2;
  logic [31:0]  h1, h2, h3, h4, h5, h6, hv, hs;
  logic [63:0]  p1, p2, p3, p4, p5, p6, p7, p8, p9, pv1, pq;

  assign t1  = {48'b0, temp_trim_r[15:0]};
  assign t2  = sx16(temp_trim_r[31:16]);
  assign t3  = sx16(temp_trim_r[47:32]);
  assign d1  = {47'b0, raw_r[19:3]} - {47'b0, temp_trim_r[15:0], 1'b0};
  assign d2  = {48'b0, raw_r[19:4]} - t1;

  assign h1  = {24'b0, hum_trim_r[7:0]};
  assign h2  = {{16{hum_trim_r[23]}}, hum_trim_r[23:8]};
  assign h3  = {24'b0, hum_trim_r[31:24]};
  assign h4  = {{20{hum_trim_r[43]}}, hum_trim_r[43:32]};
  assign h5  = {{20{hum_trim_r[55]}}, hum_trim_r[55:44]};
  assign h6  = {{24{hum_trim_r[63]}}, hum_trim_r[63:56]};
  assign hv  = fine_temp_r - HUM_T_OFS;
  assign hs  = sra32(rc_r[31:0], 5'd15);

  assign p1  = {48'b0, press_a_r[15:0]};
  assign p2  = sx16(press_a_r[31:16]);
  assign p3  = sx16(press_a_r[47:32]);
  assign p4  = sx16(press_a_r[63:48]);
  assign p5  = sx16(press_b_r[15:0]);
  assign p6  = sx16(press_b_r[31:16]);
  assign p7  = sx16(press_b_r[47:32]);
  assign p8  = sx16(press_b_r[63:48]);
  assign p9  = sx16(press_c_r);
  assign pv1 = {{32{fine_temp_r[31]}}, fine_temp_r} - PRESS_T_OFS;
  assign pq  = sra64(ra_r, 6'd13);

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

  // Multiplier operand select per step
  always_comb begin
    mul_en = 1'b1;
    mx     = 64'b0;
    my     = 64'b0;
    case (step_r)
      S_T0:  begin mx = d1; my = t2; end
      S_T1:  begin mx = d2; my = d2; end
      S_T2:  begin mx = rb_r; my = t3; end
      S_H0:  begin mx = {32'b0, h5}; my = {32'b0, hv}; end
      S_H2:  begin mx = {32'b0, hv}; my = {32'b0, h6}; end
      S_H3:  begin mx = {32'b0, hv}; my = {32'b0, h3}; end
      S_H4:  begin mx = rb_r; my = rc_r; end
      S_H5:  begin mx = rd_r; my = {32'b0, h2}; end
      S_H6:  begin mx = ra_r; my = rb_r; end
      S_H7:  begin mx = {32'b0, hs}; my = {32'b0, hs}; end
      S_H8:  begin mx = rd_r; my = {32'b0, h1}; end
      S_P0:  begin mx = pv1; my = pv1; end
      S_P1:  begin mx = ra_r; my = p6; end
      S_P2:  begin mx = pv1; my = p5; end
      S_P4:  begin mx = ra_r; my = p3; end
      S_P5:  begin mx = pv1; my = p2; end
      S_P7:  begin mx = rc_r; my = p1; end
      S_P9:  begin mx = rd_r; my = PRESS_SCALE; end
      S_P12: begin mx = p9; my = pq; end
      S_P13: begin mx = rb_r; my = pq; end
      S_P14: begin mx = p8; my = ra_r; end
      default: mul_en = 1'b0;
    endcase
  end

  // Shared 32x32 partial-product multiplier
  assign mul_a  = (phase_r == 3'd2) ? mx[63:32] : mx[31:0];
  assign mul_b  = (phase_r == 3'd1) ? my[63:32] : my[31:0];
  assign pp_nxt = {32'b0, mul_a} * {32'b0, mul_b};

  // Sequencer: next state and datapath writes
  always_comb begin
    logic [31:0] w;
    logic [31:0] tmp32;
    logic [63:0] trial_sh;
    logic [64:0] trial;
    logic [63:0] tval;

    state_nxt     = state_r;
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;
    ft_valid_nxt  = ft_valid_r;
    fine_temp_nxt = fine_temp_r;
    raw_nxt       = raw_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    rc_nxt        = rc_r;
    rd_nxt        = rd_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    dq_nxt        = dq_r;
    dvs_nxt       = dvs_r;
    rem_nxt       = rem_r;
    dneg_nxt      = dneg_r;
    res_val_nxt   = res_val_r;
    res_err_nxt   = res_err_r;
    out_value_nxt = out_value_r;
    out_error_nxt = out_error_r;
    w             = prod_r[31:0];
    tmp32         = 32'b0;
    trial_sh      = {rem_r[62:0], dq_r[63]};
    trial         = {rem_r, dq_r[63]};
    tval          = rc_r + {rc_r[61:0], 2'b0} + 64'd128;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          raw_nxt     = in_raw_value;
          phase_nxt   = 3'd0;
          res_val_nxt = 32'b0;
          res_err_nxt = 1'b0;
          case (in_req_type)
            REQ_TEMP: begin
              step_nxt  = S_T0;
              state_nxt = ST_RUN;
            end
            REQ_HUM: begin
              step_nxt    = S_H0;
              state_nxt   = ft_valid_r ? ST_RUN : ST_OUT;
              res_err_nxt = !ft_valid_r;
            end
            REQ_PRESS: begin
              step_nxt    = S_P0;
              state_nxt   = ft_valid_r ? ST_RUN : ST_OUT;
              res_err_nxt = !ft_valid_r;
            end
            default: state_nxt = ST_OUT;
          endcase
        end
      end

      ST_RUN: begin
        if (mul_en && phase_r != MUL_LAST) begin
          // accumulate low product and the two cross terms
          phase_nxt = phase_r + 3'd1;
          case (phase_r)
            3'd0: ;
            3'd1: acc_nxt = pp_r;
            3'd2: acc_nxt = acc_r + {pp_r[31:0], 32'b0};
            default: prod_nxt = acc_r + {pp_r[31:0], 32'b0};
          endcase
        end else begin
          phase_nxt = 3'd0;
          step_nxt  = step_t'(step_r + 6'd1);
          case (step_r)
            // temperature
            S_T0: ra_nxt = sra64(prod_r, 6'd11);
            S_T1: rb_nxt = sra64(prod_r, 6'd12);
            S_T2: rb_nxt = sra64(prod_r, 6'd14);
            S_T3: rc_nxt = ra_r + rb_r;
            S_T4: begin
              fine_temp_nxt = rc_r[31:0];
              ft_valid_nxt  = 1'b1;
              res_val_nxt   = tval[39:8];
              state_nxt     = ST_OUT;
            end
            // humidity, 32-bit wrapping
            S_H0: begin
              tmp32  = {2'b0, raw_r[15:0], 14'b0} - {h4[11:0], 20'b0} - w;
              ra_nxt = {32'b0, tmp32};
            end
            S_H1: begin
              tmp32  = ra_r[31:0] + 32'd16384;
              ra_nxt = {32'b0, sra32(tmp32, 5'd15)};
            end
            S_H2: rb_nxt = {32'b0, sra32(w, 5'd10)};
            S_H3: rc_nxt = {32'b0, sra32(w, 5'd11) + 32'd32768};
            S_H4: rd_nxt = {32'b0, sra32(w, 5'd10) + 32'd2097152};
            S_H5: begin
              tmp32  = w + 32'd8192;
              rb_nxt = {32'b0, sra32(tmp32, 5'd14)};
            end
            S_H6: rc_nxt = {32'b0, w};
            S_H7: rd_nxt = {32'b0, sra32(w, 5'd7)};
            S_H8: rd_nxt = {32'b0, rc_r[31:0] - sra32(w, 5'd4)};
            S_H9: begin
              tmp32 = rd_r[31:0];
              if (tmp32[31]) begin
                tmp32 = 32'b0;
              end else if (tmp32 > HUM_MAX) begin
                tmp32 = HUM_MAX;
              end
              res_val_nxt = {12'b0, tmp32[31:12]};
              state_nxt   = ST_OUT;
            end
            // pressure, 64-bit wrapping
            S_P0: ra_nxt = prod_r;
            S_P1: rb_nxt = prod_r;
            S_P2: rb_nxt = rb_r + {prod_r[46:0], 17'b0};
            S_P3: rb_nxt = rb_r + {p4[28:0], 35'b0};
            S_P4: rc_nxt = sra64(prod_r, 6'd8);
            S_P5: rc_nxt = rc_r + {prod_r[51:0], 12'b0};
            S_P6: rc_nxt = rc_r + {16'b0, 1'b1, 47'b0};
            S_P7: rc_nxt = sra64(prod_r, 6'd33);
            S_P8: begin
              if (rc_r == 64'b0) begin
                res_val_nxt = 32'b0;
                state_nxt   = ST_OUT;
              end else begin
                tval   = PRESS_FS - {44'b0, raw_r};
                rd_nxt = {tval[32:0], 31'b0} - rb_r;
              end
            end
            S_P9: rd_nxt = prod_r;
            S_P10: begin
              // magnitudes into the divider
              dneg_nxt    = rd_r[63] ^ rc_r[63];
              dq_nxt      = rd_r[63] ? (64'b0 - rd_r) : rd_r;
              dvs_nxt     = rc_r[63] ? (64'b0 - rc_r) : rc_r;
              rem_nxt     = 64'b0;
              div_cnt_nxt = 6'd0;
              state_nxt   = ST_DIV;
            end
            S_P11: ra_nxt = dneg_r ? (64'b0 - dq_r) : dq_r;
            S_P12: rb_nxt = prod_r;
            S_P13: rb_nxt = sra64(prod_r, 6'd25);
            S_P14: rc_nxt = sra64(prod_r, 6'd19);
            S_P15: rd_nxt = ra_r + rb_r;
            S_P16: rd_nxt = rd_r + rc_r;
            S_P17: rd_nxt = sra64(rd_r, 6'd8) + {p7[59:0], 4'b0};
            S_P18: begin
              if (rd_r[63]) begin
                res_val_nxt = 32'b0;
              end else if (rd_r > PRESS_MAX) begin
                res_val_nxt = PRESS_MAX[31:0];
              end else begin
                res_val_nxt = rd_r[31:0];
              end
              state_nxt = ST_OUT;
            end
            default: state_nxt = ST_OUT;
          endcase
        end
      end

      // restoring divider, one quotient bit per cycle
      ST_DIV: begin
        if (trial >= {1'b0, dvs_r}) begin
          rem_nxt = trial_sh - dvs_r;
          dq_nxt  = {dq_r[62:0], 1'b1};
        end else begin
          rem_nxt = trial_sh;
          dq_nxt  = {dq_r[62:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + 6'd1;
        if (div_cnt_r == 6'd63) begin
          state_nxt = ST_RUN;
          step_nxt  = S_P11;
        end
      end

      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_value_nxt = res_val_r;
          out_error_nxt = res_err_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and trim registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= S_T0;
      phase_r     <= 3'd0;
      div_cnt_r   <= 6'd0;
      out_valid_r <= 1'b0;
      ft_valid_r  <= 1'b0;
      fine_temp_r <= 32'b0;
      temp_trim_r <= 48'b0;
      press_a_r   <= 64'b0;
      press_b_r   <= 64'b0;
      press_c_r   <= 16'b0;
      hum_trim_r  <= 64'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      ft_valid_r  <= ft_valid_nxt;
      fine_temp_r <= fine_temp_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TEMP_TRIM:    temp_trim_r <= cfg_data[47:0];
          REG_PRESS_TRIM_A: press_a_r   <= cfg_data;
          REG_PRESS_TRIM_B: press_b_r   <= cfg_data;
          REG_PRESS_TRIM_C: press_c_r   <= cfg_data[15:0];
          REG_HUM_TRIM:     hum_trim_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    raw_r       <= raw_nxt;
    ra_r        <= ra_nxt;
    rb_r        <= rb_nxt;
    rc_r        <= rc_nxt;
    rd_r        <= rd_nxt;
    pp_r        <= pp_nxt;
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    dq_r        <= dq_nxt;
    dvs_r       <= dvs_nxt;
    rem_r       <= rem_nxt;
    dneg_r      <= dneg_nxt;
    res_val_r   <= res_val_nxt;
    res_err_r   <= res_err_nxt;
    out_value_r <= out_value_nxt;
    out_error_r <= out_error_nxt;
  end

endmodule

### dv/tb_env_sensor_compensation_unit.sv
`timescale 1ns / 1ps

module tb_env_sensor_compensation_unit;
  import esc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_LEN    = 400;

  typedef struct packed {
    logic [1:0]  req;
    logic [19:0] raw;
  } reading_t;

  typedef struct packed {
    logic [31:0] value;
    logic        error;
  } comp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = REQ_TEMP;
  logic [19:0] in_raw_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_value;
  logic out_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  env_sensor_compensation_unit dut (.*);

  always #6 clk = ~clk;

  // Shadow trim registers and fine-temperature state
  logic [63:0] sh_temp_trim, sh_press_a, sh_press_b, sh_press_c, sh_hum_trim;
  logic [31:0] sh_fine;
  logic        sh_fine_ok;

  reading_t     pending_q[$];
  comp_result_t compensated_q[$];
  int  errors = 0;
  int  n_temp = 0, n_hum = 0, n_press = 0, n_flagged = 0, n_checked = 0;
  bit  quiet = 1'b0;
  bit  hold_go = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_cnt = 0;
  int  cycles = 0;

  task automatic report(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic longint sdiv(input longint a, input longint b);
    if (b == -64'sd1) return -a;
    return a / b;
  endfunction

  function automatic logic [31:0] temp_comp(input logic [19:0] raw_in);
    longint raw, t1, t2, t3, d1, d2, v1, v2, fine;
    raw = longint'({44'b0, raw_in});
    t1 = longint'({48'b0, sh_temp_trim[15:0]});
    t2 = longint'($signed(sh_temp_trim[31:16]));
    t3 = longint'($signed(sh_temp_trim[47:32]));
    d1 = (raw >>> 3) - (t1 <<< 1);
    v1 = (d1 * t2) >>> 11;
    d2 = (raw >>> 4) - t1;
    v2 = (((d2 * d2) >>> 12) * t3) >>> 14;
    fine = v1 + v2;
    sh_fine = fine[31:0];
    sh_fine_ok = 1'b1;
    fine = (fine * 5 + 128) >>> 8;
    return fine[31:0];
  endfunction

  function automatic logic [31:0] hum_comp(input logic [19:0] raw_in);
    int raw, h1, h2, h3, h4, h5, h6, v, a, b, c, d, e, s;
    raw = int'({16'b0, raw_in[15:0]});
    h1 = int'({24'b0, sh_hum_trim[7:0]});
    h2 = int'($signed(sh_hum_trim[23:8]));
    h3 = int'({24'b0, sh_hum_trim[31:24]});
    h4 = int'($signed(sh_hum_trim[43:32]));
    h5 = int'($signed(sh_hum_trim[55:44]));
    h6 = int'($signed(sh_hum_trim[63:56]));
    v = $signed(sh_fine) - 76800;
    a = (raw << 14) - (h4 << 20) - h5 * v;
    a = (a + 16384) >>> 15;
    b = (v * h6) >>> 10;
    c = ((v * h3) >>> 11) + 32768;
    d = (b * c) >>> 10;
    e = ((d + 2097152) * h2 + 8192) >>> 14;
    v = a * e;
    s = v >>> 15;
    v = v - ((((s * s) >>> 7) * h1) >>> 4);
    if (v < 0) v = 0;
    if (v > 419430400) v = 419430400;
    return v >> 12;
  endfunction

  function automatic logic [31:0] press_comp(input logic [19:0] raw_in);
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, q;
    p1 = longint'({48'b0, sh_press_a[15:0]});
    p2 = longint'($signed(sh_press_a[31:16]));
    p3 = longint'($signed(sh_press_a[47:32]));
    p4 = longint'($signed(sh_press_a[63:48]));
    p5 = longint'($signed(sh_press_b[15:0]));
    p6 = longint'($signed(sh_press_b[31:16]));
    p7 = longint'($signed(sh_press_b[47:32]));
    p8 = longint'($signed(sh_press_b[63:48]));
    p9 = longint'($signed(sh_press_c[15:0]));
    v1 = longint'($signed(sh_fine)) - 128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((longint'(1) <<< 47) + v1) * p1) >>> 33;
    if (v1 == 0) return '0;
    p = 1048576 - longint'({44'b0, raw_in});
    p = sdiv(((p <<< 31) - v2) * 3125, v1);
    q = p >>> 13;
    v1 = (p9 * q * q) >>> 25;
    v2 = (p8 * p) >>> 19;
    p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
    if (p < 0) return '0;
    if (p > 33554431) return 32'd33554431;
    return p[31:0];
  endfunction

  function automatic comp_result_t compensate(input reading_t rd);
    comp_result_t r;
    r = '0;
    case (rd.req)
      REQ_TEMP: begin
        r.value = temp_comp(rd.raw);
        n_temp++;
      end
      REQ_HUM, REQ_PRESS: begin
        if (!sh_fine_ok) begin
          r.error = 1'b1;
          n_flagged++;
        end else if (rd.req == REQ_HUM) begin
          r.value = hum_comp(rd.raw);
          n_hum++;
        end else begin
          r.value = press_comp(rd.raw);
          n_press++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: offer queued words, predict on acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        compensated_q.push_back(compensate(reading_t'({in_req_type, in_raw_value})));
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && (quiet || $urandom_range(99) >= 23)) begin
          reading_t rd;
          rd = pending_q.pop_front();
          in_valid <= 1'b1;
          in_req_type <= rd.req;
          in_raw_value <= rd.raw;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, counted here
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_cnt <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Monitor: random stall and result check
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        comp_result_t want;
        if (compensated_q.size() == 0) begin
          report($sformatf("unexpected word value=%0h error=%0b", out_value, out_error));
        end else begin
          want = compensated_q.pop_front();
          n_checked++;
          if (out_value !== want.value)
            report($sformatf("value %0h, want %0h", out_value, want.value));
          if (out_error !== want.error)
            report($sformatf("error %0b, want %0b", out_error, want.error));
        end
      end
      out_stall <= (hold_cnt > 0) || (!quiet && $urandom_range(99) < 23);
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_trim(input logic [2:0] idx, input logic [63:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TEMP_TRIM:    sh_temp_trim = {16'b0, d[47:0]};
      REG_PRESS_TRIM_A: sh_press_a = d;
      REG_PRESS_TRIM_B: sh_press_b = d;
      REG_PRESS_TRIM_C: sh_press_c = {48'b0, d[15:0]};
      REG_HUM_TRIM:     sh_hum_trim = d;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || compensated_q.size() != 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_trims(input logic [63:0] t, a, b, c, h);
    wait_drained();
    write_trim(REG_TEMP_TRIM, t);
    write_trim(REG_PRESS_TRIM_A, a);
    write_trim(REG_PRESS_TRIM_B, b);
    write_trim(REG_PRESS_TRIM_C, c);
    write_trim(REG_HUM_TRIM, h);
  endtask

  // Typical trims, with random low bits flipped when jitter is nonzero
  task automatic load_typical(input int jitter);
    logic [63:0] t, a, b, h;
    t = {16'hFC18, 16'd26435, 16'd27504};
    a = {16'd2855, 16'd3024, 16'hD843, 16'd36477};
    b = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    h = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};
    if (jitter > 0) begin
      t ^= 64'($urandom_range(jitter));
      a ^= 64'($urandom_range(jitter));
      b ^= 64'($urandom_range(jitter));
      h ^= 64'($urandom_range(jitter));
    end
    load_trims(t, a, b, 64'd6000, h);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push(input logic [1:0] req, input logic [19:0] raw);
    pending_q.push_back(reading_t'({req, raw}));
  endtask

  // Mostly plausible readings with random spread; the rest fully random
  task automatic push_random(input int n);
    int pick;
    logic [19:0] raw;
    logic [1:0]  req;
    repeat (n) begin
      pick = $urandom_range(99);
      req = pick < 35 ? REQ_TEMP : pick < 65 ? REQ_HUM : pick < 95 ? REQ_PRESS : REQ_NONE;
      raw = 20'($urandom);
      if ($urandom_range(99) < 70) begin
        case (req)
          REQ_TEMP:  raw = 20'd480000 + 20'($urandom_range(80000));
          REQ_HUM:   raw = 20'($urandom_range(60000));
          REQ_PRESS: raw = 20'd300000 + 20'($urandom_range(250000));
          default: ;
        endcase
      end
      push(req, raw);
    end
  endtask

  initial begin
    sh_temp_trim = '0;
    sh_press_a = '0;
    sh_press_b = '0;
    sh_press_c = '0;
    sh_hum_trim = '0;
    sh_fine = '0;
    sh_fine_ok = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: no temperature yet, then zero trims (zero divisor)
    push(REQ_HUM, 20'd30000);
    push(REQ_PRESS, 20'd415148);
    push(REQ_NONE, 20'hFFFFF);
    push(REQ_TEMP, 20'd0);
    push(REQ_HUM, 20'hFFFFF);
    push(REQ_PRESS, 20'd415148);
    push(REQ_TEMP, 20'hFFFFF);

    load_typical(0);
    push(REQ_TEMP, 20'd519888);
    push(REQ_HUM, 20'd30000);
    push(REQ_HUM, 20'hF0000);
    push(REQ_HUM, 20'h0FFFF);
    push(REQ_HUM, 20'd0);
    push(REQ_PRESS, 20'd415148);
    push(REQ_PRESS, 20'd0);
    push(REQ_PRESS, 20'hFFFFF);
    push(REQ_NONE, 20'd0);

    // Extreme trims
    load_trims('1, '1, '1, '1, '1);
    push(REQ_TEMP, 20'hFFFFF);
    push(REQ_HUM, 20'hFFFFF);
    push(REQ_PRESS, 20'd0);
    load_trims(64'h8000_8000_0000, 64'h8000_8000_8000_FFFF, 64'h8000_7FFF_8000_7FFF,
               64'h8000, 64'h80_800_800_00_8000_FF);
    push(REQ_TEMP, 20'd0);
    push(REQ_HUM, 20'h0FFFF);
    push(REQ_PRESS, 20'hFFFFF);

    // Random: typical trims, first stretch without idling
    load_typical(0);
    quiet = 1'b1;
    push_random(120);
    while (pending_q.size() != 0) @(posedge clk);
    quiet = 1'b0;
    push_random(230);

    // Perturbed trims with a long receiver hold
    load_typical(255);
    push_random(300);
    @(posedge clk);
    hold_go <= 1'b1;

    // Fully random trims, sender pauses mid-phase until drained
    load_trims(rand64(), rand64(), rand64(), rand64(), rand64());
    push_random(150);
    wait_drained();
    push_random(150);

    // Typical trims again
    load_typical(15);
    push_random(250);
    wait_drained();

    $display("covered %0d temperature, %0d humidity, %0d pressure readings, %0d flagged",
             n_temp, n_hum, n_press, n_flagged);
    $display("%0d words checked over typical, perturbed, random and extreme trims", n_checked);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/esc_pkg.sv
rtl/core/env_sensor_compensation_unit.sv
dv/tb_env_sensor_compensation_unit.sv
